// ===== src/led_blink_pattern_sequencer_defines.svh =====
// Assertion macros shared by the LED blink pattern sequencer RTL.
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBPS_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define LBPS_ASSERT_ALWAYS(label, ck, prop, msg) \
    label: assert property (@(posedge ck) (prop)) else $error(msg);
`else
`define LBPS_ASSERT(label, ck, rn, prop, msg)
`define LBPS_ASSERT_ALWAYS(label, ck, prop, msg)
`endif
`endif

// ===== src/lbps_pkg.sv =====
// Types and constants of the LED blink pattern sequencer.
`default_nettype none
package lbps_pkg;

    localparam int KIND_W     = 2;
    localparam int LED_IDX_W  = 2;
    localparam int PAT_W      = 3;
    localparam int COUNT_W    = 8;
    localparam int LEVELS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIMER_W    = 17;
    localparam int BURST_W    = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX   = '1;
    localparam logic [PAT_W-1:0]   PAT_INVALID = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    typedef enum logic [PAT_W-1:0] {
        PAT_OFF  = 3'd0,
        PAT_ON   = 3'd1,
        PAT_FAST = 3'd2,
        PAT_SLOW = 3'd3,
        PAT_ERR1 = 3'd4,
        PAT_ERR2 = 3'd5,
        PAT_ERR3 = 3'd6
    } pattern_t;

    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_ON    = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_HALF   = 3'd0,
        CFG_SLOW_HALF   = 3'd1,
        CFG_ERROR_ON    = 3'd2,
        CFG_ERROR_GAP   = 3'd3,
        CFG_ERROR_PAUSE = 3'd4,
        CFG_COUNT_ON    = 3'd5,
        CFG_COUNT_OFF   = 3'd6,
        CFG_COUNT_PAUSE = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] fast_half_ms;
        logic [CFG_DATA_W-1:0] slow_half_ms;
        logic [CFG_DATA_W-1:0] error_on_ms;
        logic [CFG_DATA_W-1:0] error_gap_ms;
        logic [CFG_DATA_W-1:0] error_pause_ms;
        logic [CFG_DATA_W-1:0] count_on_ms;
        logic [CFG_DATA_W-1:0] count_off_ms;
        logic [CFG_DATA_W-1:0] count_pause_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fast_half_ms:   16'd250,
        slow_half_ms:   16'd1000,
        error_on_ms:    16'd150,
        error_gap_ms:   16'd150,
        error_pause_ms: 16'd1000,
        count_on_ms:    16'd200,
        count_off_ms:   16'd200,
        count_pause_ms: 16'd1000
    };

    // Command as seen by one LED unit
    typedef struct packed {
        kind_t              kind;
        logic               hit;
        logic               pattern_ok;
        pattern_t           pattern;
        logic [COUNT_W-1:0] count;
    } led_cmd_t;

endpackage
`default_nettype wire

// ===== src/lbps_cmd_if.sv =====
// Command channel: valid/ready with one command item as payload.
`default_nettype none
interface lbps_cmd_if;
    import lbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [LED_IDX_W-1:0] led_index;
    logic [PAT_W-1:0]     pattern_code;
    logic [COUNT_W-1:0]   blink_count;

    modport source (output valid, kind, led_index, pattern_code, blink_count, input ready);
    modport sink   (input valid, kind, led_index, pattern_code, blink_count, output ready);
endinterface
`default_nettype wire

// ===== src/lbps_rsp_if.sv =====
// Result channel: valid/ready with LED levels, done flags and status.
`default_nettype none
interface lbps_rsp_if;
    import lbps_pkg::*;

    logic                valid;
    logic                ready;
    logic [LEVELS_W-1:0] led_levels;
    logic [LEVELS_W-1:0] done_mask;
    logic                status;

    modport source (output valid, led_levels, done_mask, status, input ready);
    modport sink   (input valid, led_levels, done_mask, status, output ready);
endinterface
`default_nettype wire

// ===== src/led_blink_pattern_sequencer.sv =====
// Top level of the two-LED blink pattern sequencer.
// Each accepted command item (tick, pattern set, or counted-blink start) yields one result
// item with the LED levels after it, the counted-blink done flags and a status bit. The block
// takes one item per clock cycle while the result side does not stall; an item passes an
// input register, the per-LED update logic, and a result register that offers its result.
// A stalled result holds the input register, and the command side then stalls. The LED units
// update their state as an item moves from the input register into the result register.
// The user must write timing registers through the plain write port only while no item is in
// flight; the block itself does not enforce this.
`default_nettype none
`include "led_blink_pattern_sequencer_defines.svh"
module led_blink_pattern_sequencer #(
    parameter int TICK_MS   = 10,
    parameter int MAX_COUNT = 15,
    parameter int NUM_LEDS  = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lbps_cmd_if.sink                         cmd,
    lbps_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lbps_pkg::*;

    logic                  in_valid_reg;
    logic [KIND_W-1:0]     in_kind_reg;
    logic [LED_IDX_W-1:0]  in_led_reg;
    logic [PAT_W-1:0]      in_pat_reg;
    logic [COUNT_W-1:0]    in_count_reg;

    logic                  out_valid_reg;
    logic [LEVELS_W-1:0]   levels_reg;
    logic [LEVELS_W-1:0]   done_reg;
    logic                  status_reg;

    logic                  adv;
    logic                  led_bad;
    logic                  status_next;
    logic [LEVELS_W-1:0]   led_level;
    logic [LEVELS_W-1:0]   led_done;
    cfg_t                  cfg;

    // Move the held item into the result register when that slot frees up
    assign adv       = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || adv;

    // Capture a command on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_kind_reg  <= cmd.kind;
            in_led_reg   <= cmd.led_index;
            in_pat_reg   <= cmd.pattern_code;
            in_count_reg <= cmd.blink_count;
        end
    end

    lbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // One state machine per LED; unused slots read zero
    for (genvar i = 0; i < LEVELS_W; i++)
    begin : g_led
        if (i < NUM_LEDS)
        begin : g_unit
            led_cmd_t led_cmd;

            assign led_cmd.kind       = kind_t'(in_kind_reg);
            assign led_cmd.hit        = (in_led_reg == LED_IDX_W'(i));
            assign led_cmd.pattern_ok = (in_pat_reg != PAT_INVALID);
            assign led_cmd.pattern    = pattern_t'(in_pat_reg);
            assign led_cmd.count      = in_count_reg;

            lbps_led_unit #(
                .TICK_MS   (TICK_MS),
                .MAX_COUNT (MAX_COUNT)
            ) u_led (
                .clk    (clk),
                .rst_n  (rst_n),
                .enable (adv),
                .cmd    (led_cmd),
                .cfg    (cfg),
                .level  (led_level[i]),
                .done   (led_done[i])
            );
        end
        else
        begin : g_none
            assign led_level[i] = 1'b0;
            assign led_done[i]  = 1'b0;
        end
    end

    // Flag an invalid LED index or pattern code
    assign led_bad = (in_led_reg >= LED_IDX_W'(NUM_LEDS));

    always_comb
    begin
        case (kind_t'(in_kind_reg))
            KIND_SET:   status_next = led_bad || (in_pat_reg == PAT_INVALID);
            KIND_COUNT: status_next = led_bad;
            default:    status_next = 1'b0;
        endcase
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            levels_reg <= led_level;
            done_reg   <= led_done;
            status_reg <= status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.led_levels = levels_reg;
    assign rsp.done_mask  = done_reg;
    assign rsp.status     = status_reg;

    `LBPS_ASSERT(a_adv_fills_result, clk, rst_n, adv |=> out_valid_reg, "processed item lost before result stage")

endmodule
`default_nettype wire

// ===== src/lbps_cfg_regs.sv =====
// Timing register file of the LED blink pattern sequencer.
`default_nettype none
module lbps_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lbps_pkg::cfg_t                   cfg
);
    import lbps_pkg::*;

    cfg_t cfg_reg;

    // Load the addressed register on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FAST_HALF:   cfg_reg.fast_half_ms   <= cfg_data;
                CFG_SLOW_HALF:   cfg_reg.slow_half_ms   <= cfg_data;
                CFG_ERROR_ON:    cfg_reg.error_on_ms    <= cfg_data;
                CFG_ERROR_GAP:   cfg_reg.error_gap_ms   <= cfg_data;
                CFG_ERROR_PAUSE: cfg_reg.error_pause_ms <= cfg_data;
                CFG_COUNT_ON:    cfg_reg.count_on_ms    <= cfg_data;
                CFG_COUNT_OFF:   cfg_reg.count_off_ms   <= cfg_data;
                CFG_COUNT_PAUSE: cfg_reg.count_pause_ms <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== src/lbps_led_unit.sv =====
// Per-LED pattern and counted-blink state machine.
`default_nettype none
`include "led_blink_pattern_sequencer_defines.svh"
module lbps_led_unit #(
    parameter int TICK_MS   = 10,
    parameter int MAX_COUNT = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  lbps_pkg::led_cmd_t  cmd,
    input  lbps_pkg::cfg_t      cfg,
    output logic                level,
    output logic                done
);
    import lbps_pkg::*;

    pattern_t               pattern_reg,  pattern_next;
    logic [TIMER_W-1:0]     timer_reg,    timer_next;
    phase_t                 phase_reg,    phase_next;
    logic [BURST_W-1:0]     burst_reg,    burst_next;
    logic                   active_reg,   active_next;
    logic [COUNT_W-1:0]     target_reg,   target_next;
    logic [COUNT_W-1:0]     done_cnt_reg, done_cnt_next;
    pattern_t               saved_reg,    saved_next;

    logic [TIMER_W:0]       timer_sum;
    logic [TIMER_W-1:0]     timer_inc;
    logic [CFG_DATA_W-1:0]  half_ms;
    logic [PAT_W-1:0]       pat_bits;
    logic [BURST_W-1:0]     burst_target;
    logic [BURST_W-1:0]     burst_n;
    logic [COUNT_W-1:0]     done_inc;
    logic [COUNT_W-1:0]     count_clamped;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= PAT_OFF;
            timer_reg    <= '0;
            phase_reg    <= PH_OFF;
            burst_reg    <= '0;
            active_reg   <= 1'b0;
            target_reg   <= '0;
            done_cnt_reg <= '0;
            saved_reg    <= PAT_OFF;
        end
        else
        begin
            pattern_reg  <= pattern_next;
            timer_reg    <= timer_next;
            phase_reg    <= phase_next;
            burst_reg    <= burst_next;
            active_reg   <= active_next;
            target_reg   <= target_next;
            done_cnt_reg <= done_cnt_next;
            saved_reg    <= saved_next;
        end
    end

    // Saturating timer step and helper values
    assign timer_sum     = {1'b0, timer_reg} + (TIMER_W+1)'(TICK_MS);
    assign timer_inc     = (timer_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : timer_sum[TIMER_W-1:0];
    assign half_ms       = (pattern_reg == PAT_FAST) ? cfg.fast_half_ms : cfg.slow_half_ms;
    assign pat_bits      = pattern_reg;
    assign burst_target  = BURST_W'(pat_bits - 3'd3);
    assign burst_n       = burst_reg + 2'd1;
    assign done_inc      = (done_cnt_reg == '1) ? done_cnt_reg : done_cnt_reg + 8'd1;
    assign count_clamped = (cmd.count > COUNT_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT) : cmd.count;

    // Advance the pattern, the counted blink, or take a command
    always_comb
    begin
        pattern_next  = pattern_reg;
        timer_next    = timer_reg;
        phase_next    = phase_reg;
        burst_next    = burst_reg;
        active_next   = active_reg;
        target_next   = target_reg;
        done_cnt_next = done_cnt_reg;
        saved_next    = saved_reg;
        done          = 1'b0;

        if (enable)
        begin
            case (cmd.kind)
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        timer_next = timer_inc;
                        case (phase_reg)
                            PH_ON:
                            begin
                                if (timer_inc >= {1'b0, cfg.count_on_ms})
                                begin
                                    timer_next    = '0;
                                    done_cnt_next = done_inc;
                                    phase_next    = (done_inc >= target_reg) ? PH_PAUSE : PH_OFF;
                                end
                            end
                            PH_OFF:
                            begin
                                if (timer_inc >= {1'b0, cfg.count_off_ms})
                                begin
                                    phase_next = PH_ON;
                                    timer_next = '0;
                                end
                            end
                            default:
                            begin
                                // End of pause: restore the saved pattern
                                if (timer_inc >= {1'b0, cfg.count_pause_ms})
                                begin
                                    active_next  = 1'b0;
                                    pattern_next = saved_reg;
                                    timer_next   = '0;
                                    burst_next   = '0;
                                    phase_next   = (saved_reg == PAT_ON) ? PH_ON : PH_OFF;
                                    done         = 1'b1;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        case (pattern_reg)
                            PAT_OFF: phase_next = PH_OFF;
                            PAT_ON:  phase_next = PH_ON;
                            PAT_FAST, PAT_SLOW:
                            begin
                                timer_next = timer_inc;
                                if ((phase_reg == PH_OFF || phase_reg == PH_ON)
                                    && timer_inc >= {1'b0, half_ms})
                                begin
                                    phase_next = (phase_reg == PH_OFF) ? PH_ON : PH_OFF;
                                    timer_next = '0;
                                end
                            end
                            PAT_ERR1, PAT_ERR2, PAT_ERR3:
                            begin
                                timer_next = timer_inc;
                                case (phase_reg)
                                    PH_OFF:
                                    begin
                                        if (timer_inc >= {1'b0, cfg.error_gap_ms})
                                        begin
                                            phase_next = PH_ON;
                                            timer_next = '0;
                                        end
                                    end
                                    PH_ON:
                                    begin
                                        if (timer_inc >= {1'b0, cfg.error_on_ms})
                                        begin
                                            timer_next = '0;
                                            if (burst_n >= burst_target)
                                            begin
                                                phase_next = PH_PAUSE;
                                                burst_next = '0;
                                            end
                                            else
                                            begin
                                                phase_next = PH_OFF;
                                                burst_next = burst_n;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        if (timer_inc >= {1'b0, cfg.error_pause_ms})
                                        begin
                                            phase_next = PH_OFF;
                                            timer_next = '0;
                                        end
                                    end
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_SET:
                begin
                    if (cmd.hit && cmd.pattern_ok)
                    begin
                        pattern_next = cmd.pattern;
                        timer_next   = '0;
                        burst_next   = '0;
                        phase_next   = (cmd.pattern == PAT_ON) ? PH_ON : PH_OFF;
                    end
                end
                KIND_COUNT:
                begin
                    if (cmd.hit)
                    begin
                        if (cmd.count == '0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            saved_next    = pattern_reg;
                            target_next   = count_clamped;
                            done_cnt_next = '0;
                            active_next   = 1'b1;
                            phase_next    = PH_ON;
                            timer_next    = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Drive level after this item
    assign level = (phase_next == PH_ON);

    `LBPS_ASSERT(a_target_range, clk, rst_n, active_reg |-> (target_reg != '0 && target_reg <= COUNT_W'(MAX_COUNT)), "counted target out of range")
    `LBPS_ASSERT(a_off_stays_dark, clk, rst_n, (!active_reg && pattern_reg == PAT_OFF) |-> phase_reg == PH_OFF, "LED lit under off pattern")
    `LBPS_ASSERT(a_on_stays_lit, clk, rst_n, (!active_reg && pattern_reg == PAT_ON) |-> phase_reg == PH_ON, "LED dark under on pattern")
    `LBPS_ASSERT(a_burst_range, clk, rst_n, burst_reg != 2'd3, "burst index beyond three blinks")

endmodule
`default_nettype wire
